[design/vnorm_pkg.sv]
package vnorm_pkg;

   localparam int unsigned COMP_W  = 32;
   localparam int unsigned SUM_W   = 2 * COMP_W;
   localparam int unsigned ROOT_W  = COMP_W;
   localparam int unsigned QUOT_W  = 31;
   localparam int unsigned LANES   = 3;

   localparam logic [COMP_W-1:0] ONE_Q30 = 32'h4000_0000;

   typedef struct packed {
      logic [LANES-1:0]             sign;
      logic [LANES-1:0][COMP_W-1:0] absval;
   } vnorm_side_type;

endpackage

[design/vector3_normalize_unit.sv]
// Normalizes a signed Q16.16 vector to a signed Q1.30 unit vector and reports the floored
// length in unsigned Q16.16. One word is accepted per cycle while the skid register is
// empty. Each word passes through registers for absolute values, squares and their sum,
// 32 stages of the bit-pair square root and 31 stages of the three restoring divider
// lanes, and then the output register. A skid register lets the pipeline keep accepting
// while one result waits. A zero vector gives (0, 0, 1.0), length 0 and the zero flag.
module vector3_normalize_unit
   import vnorm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_comp_x,
   input  logic [31:0]       req_comp_y,
   input  logic [31:0]       req_comp_z,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_unit_x,
   output logic [31:0]       rsp_unit_y,
   output logic [31:0]       rsp_unit_z,
   output logic [31:0]       rsp_magnitude,
   output logic              rsp_zero_vector
);

   localparam int unsigned LAT    = 3 + ROOT_W + QUOT_W;
   localparam int unsigned SIDE_W = $bits(vnorm_side_type);
   localparam int unsigned RES_W  = 3 * COMP_W + ROOT_W + 1;

   logic                       ce;
   logic [LAT-1:0]             vld_ff;
   logic [COMP_W-1:0]          comp [LANES];
   vnorm_side_type             side_a_ff, side_b_ff, side_c_ff, side_s;
   logic [LANES-1:0][SUM_W-1:0] sq_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [ROOT_W-1:0]          root;
   logic [QUOT_W-1:0]          quot [LANES];
   logic [LANES-1:0]           sign_d;
   logic [ROOT_W-1:0]          mag_d;
   logic [RES_W-1:0]           res_in, out_ff, skid_ff;
   logic                       out_vld_ff, skid_vld_ff;
   logic                       push, pop;
   logic [COMP_W-1:0]          unit_in [LANES];
   logic                       zero_in;

   assign comp[0] = req_comp_x;
   assign comp[1] = req_comp_y;
   assign comp[2] = req_comp_z;

   assign ce        = !skid_vld_ff;
   assign req_ready = ce;
   assign push      = ce && vld_ff[LAT-1];
   assign pop       = out_vld_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < LANES; i++) begin
            side_a_ff.sign[i]   <= comp[i][COMP_W-1];
            side_a_ff.absval[i] <= comp[i][COMP_W-1] ? COMP_W'(-comp[i]) : comp[i];
            sq_ff[i] <= SUM_W'(side_a_ff.absval[i]) * SUM_W'(side_a_ff.absval[i]);
         end
         side_b_ff <= side_a_ff;
         sum_ff    <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         side_c_ff <= side_b_ff;
      end
   end

   vnorm_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
      .clock    (clock),
      .ce       (ce),
      .sum_in   (sum_ff),
      .side_in  (side_c_ff),
      .root_out (root),
      .side_out (side_s)
   );

   vnorm_div_lane #(.TAG_W(ROOT_W + 1)) u_div_x (
      .clock    (clock),
      .ce       (ce),
      .num_in   (side_s.absval[0]),
      .den_in   (root),
      .tag_in   ({side_s.sign[0], root}),
      .quot_out (quot[0]),
      .tag_out  ({sign_d[0], mag_d})
   );

   vnorm_div_lane #(.TAG_W(1)) u_div_y (
      .clock    (clock),
      .ce       (ce),
      .num_in   (side_s.absval[1]),
      .den_in   (root),
      .tag_in   (side_s.sign[1]),
      .quot_out (quot[1]),
      .tag_out  (sign_d[1])
   );

   vnorm_div_lane #(.TAG_W(1)) u_div_z (
      .clock    (clock),
      .ce       (ce),
      .num_in   (side_s.absval[2]),
      .den_in   (root),
      .tag_in   (side_s.sign[2]),
      .quot_out (quot[2]),
      .tag_out  (sign_d[2])
   );

   always_comb begin
      zero_in = (mag_d == '0);
      for (int i = 0; i < LANES; i++) begin
         unit_in[i] = sign_d[i] ? COMP_W'(-{1'b0, quot[i]}) : COMP_W'({1'b0, quot[i]});
      end
      if (zero_in) begin
         res_in = {COMP_W'(0), COMP_W'(0), ONE_Q30, ROOT_W'(0), 1'b1};
      end else begin
         res_in = {unit_in[0], unit_in[1], unit_in[2], mag_d, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || pop) begin
            out_ff     <= res_in;
            out_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= res_in;
            skid_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign {rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_magnitude, rsp_zero_vector} = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a word while the output register is empty");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_vector) |->
         (rsp_magnitude == '0 && rsp_unit_x == '0 && rsp_unit_z == ONE_Q30))
      else $error("zero vector result is malformed");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_vld_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("word lost while the output stalled");

   a_frozen_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff) || !$past(skid_vld_ff) || $past(pop))
      else $error("pipeline advanced while skid was full");

endmodule

[design/vnorm_sqrt.sv]
module vnorm_sqrt
   import vnorm_pkg::*;
#(
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              ce,
   input  logic [SUM_W-1:0]  sum_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic [ROOT_W-1:0] root_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int unsigned REM_W = ROOT_W + 2;
   localparam int unsigned TRY_W = REM_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SUM_W-1:0]  rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         logic [REM_W-1:0]  rem_prev;
         logic [ROOT_W-1:0] root_prev;
         logic [SUM_W-1:0]  rad_prev;
         logic [SIDE_W-1:0] side_prev;
         logic [TRY_W-1:0]  rem_sh;
         logic [TRY_W-1:0]  trial;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = sum_in;
            assign side_prev = side_in;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign rad_prev  = rad_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         always_comb begin
            rem_sh = {rem_prev, rad_prev[SUM_W-1 -: 2]};
            trial  = {2'b00, root_prev, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_prev[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (ce) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= {rad_prev[SUM_W-3:0], 2'b00};
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

[design/vnorm_div_lane.sv]
module vnorm_div_lane
   import vnorm_pkg::*;
#(
   parameter int unsigned TAG_W = 1
) (
   input  logic              clock,
   input  logic              ce,
   input  logic [COMP_W-1:0] num_in,
   input  logic [ROOT_W-1:0] den_in,
   input  logic [TAG_W-1:0]  tag_in,
   output logic [QUOT_W-1:0] quot_out,
   output logic [TAG_W-1:0]  tag_out
);

   logic [ROOT_W-1:0] rem_ff  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   logic [ROOT_W-1:0] den_ff  [QUOT_W];
   logic [TAG_W-1:0]  tag_ff  [QUOT_W];

   genvar j;
   generate
      for (j = 0; j < QUOT_W; j++) begin : g_stage
         logic [ROOT_W-1:0] rem_prev;
         logic [QUOT_W-1:0] quot_prev;
         logic [ROOT_W-1:0] den_prev;
         logic [TAG_W-1:0]  tag_prev;
         logic              bit_in;
         logic [ROOT_W:0]   rem_sh;
         logic [ROOT_W-1:0] rem_in;
         logic [QUOT_W-1:0] quot_in;

         if (j == 0) begin : g_first
            assign rem_prev  = {1'b0, num_in[COMP_W-1:1]};
            assign quot_prev = '0;
            assign den_prev  = den_in;
            assign tag_prev  = tag_in;
            assign bit_in    = num_in[0];
         end else begin : g_next
            assign rem_prev  = rem_ff[j-1];
            assign quot_prev = quot_ff[j-1];
            assign den_prev  = den_ff[j-1];
            assign tag_prev  = tag_ff[j-1];
            assign bit_in    = 1'b0;
         end

         always_comb begin
            rem_sh = {rem_prev, bit_in};
            if (rem_sh >= {1'b0, den_prev}) begin
               rem_in  = ROOT_W'(rem_sh - {1'b0, den_prev});
               quot_in = {quot_prev[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = ROOT_W'(rem_sh);
               quot_in = {quot_prev[QUOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (ce) begin
               rem_ff[j]  <= rem_in;
               quot_ff[j] <= quot_in;
               den_ff[j]  <= den_prev;
               tag_ff[j]  <= tag_prev;
            end
         end
      end
   endgenerate

   assign quot_out = quot_ff[QUOT_W-1];
   assign tag_out  = tag_ff[QUOT_W-1];

endmodule

[tb/sv/vector3_normalize_checker.sv]
module vector3_normalize_checker
   import vnorm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_comp_x,
   input  logic [31:0] req_comp_y,
   input  logic [31:0] req_comp_z,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_unit_x,
   input  logic [31:0] rsp_unit_y,
   input  logic [31:0] rsp_unit_z,
   input  logic [31:0] rsp_magnitude,
   input  logic        rsp_zero_vector,
   output int          error_count,
   output int          pending_count
);

   typedef struct {
      logic [31:0] unit_x;
      logic [31:0] unit_y;
      logic [31:0] unit_z;
      logic [31:0] magnitude;
      logic        zero_vector;
   } unit_vec_type;

   unit_vec_type expected_units[$];

   function automatic logic [63:0] abs_comp(logic [31:0] c);
      return c[31] ? 64'(-{32'd0, c}) & 64'hFFFF_FFFF : {32'd0, c};
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] s);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = s;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] scale_comp(logic [31:0] c, logic [63:0] mag);
      logic [63:0] q;
      q = (abs_comp(c) << 30) / mag;
      if (c[31]) q = -q;
      return q[31:0];
   endfunction

   function automatic unit_vec_type normalize_vec(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
      unit_vec_type r;
      logic [63:0] sum;
      logic [63:0] mag;
      sum = abs_comp(x) * abs_comp(x) + abs_comp(y) * abs_comp(y) + abs_comp(z) * abs_comp(z);
      mag = floor_root(sum);
      if (mag == 0) begin
         r.unit_x = 0;
         r.unit_y = 0;
         r.unit_z = ONE_Q30;
         r.magnitude = 0;
         r.zero_vector = 1'b1;
      end else begin
         r.unit_x = scale_comp(x, mag);
         r.unit_y = scale_comp(y, mag);
         r.unit_z = scale_comp(z, mag);
         r.magnitude = mag[31:0];
         r.zero_vector = 1'b0;
      end
      return r;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      unit_vec_type e;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_units.push_back(normalize_vec(req_comp_x, req_comp_y, req_comp_z));
         if (rsp_valid && rsp_ready) begin
            if (expected_units.size() == 0) begin
               $error("unexpected result word");
               error_count = error_count + 1;
            end else begin
               e = expected_units.pop_front();
               if (rsp_unit_x !== e.unit_x) begin
                  $error("unit_x expected %h actual %h", e.unit_x, rsp_unit_x);
                  error_count = error_count + 1;
               end
               if (rsp_unit_y !== e.unit_y) begin
                  $error("unit_y expected %h actual %h", e.unit_y, rsp_unit_y);
                  error_count = error_count + 1;
               end
               if (rsp_unit_z !== e.unit_z) begin
                  $error("unit_z expected %h actual %h", e.unit_z, rsp_unit_z);
                  error_count = error_count + 1;
               end
               if (rsp_magnitude !== e.magnitude) begin
                  $error("magnitude expected %h actual %h", e.magnitude, rsp_magnitude);
                  error_count = error_count + 1;
               end
               if (rsp_zero_vector !== e.zero_vector) begin
                  $error("zero_vector expected %b actual %b", e.zero_vector, rsp_zero_vector);
                  error_count = error_count + 1;
               end
            end
         end
         pending_count = expected_units.size();
      end
   end

endmodule

[tb/sv/tb_vector3_normalize_unit.sv]
module tb_vector3_normalize_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_comp_x = '0;
   logic [31:0] req_comp_y = '0;
   logic [31:0] req_comp_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_unit_x;
   logic [31:0] rsp_unit_y;
   logic [31:0] rsp_unit_z;
   logic [31:0] rsp_magnitude;
   logic        rsp_zero_vector;
   int          error_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          bursty = 1'b0;

   localparam int CYCLE_LIMIT = 400000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vector3_normalize_unit u_top (.*);

   vector3_normalize_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int wait_n;
      forever begin
         @(posedge clock);
         wait_n = bursty ? 0 : $urandom_range(0, 13);
         if (wait_n != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [31:0] pick_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 40)) - 20);
         3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         4: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int wait_n;
      wait_n = bursty ? 0 : $urandom_range(0, 13);
      if (wait_n != 0) begin
         req_valid <= 1'b0;
         repeat (wait_n) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      logic [31:0] edge_vals[8];
      edge_vals = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_vec(0, 0, 0);
      send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vec(32'h8000_0000, 0, 0);
      send_vec(0, 32'h8000_0000, 0);
      send_vec(0, 0, 32'h8000_0000);
      send_vec(1, 0, 0);
      send_vec(0, 32'hFFFF_FFFF, 0);
      send_vec(0, 0, 1);
      send_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      for (int i = 0; i < 12; i++)
         send_vec(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
                  edge_vals[$urandom_range(0, 7)]);
      for (int i = 0; i < 1350; i++) begin
         if (i % 200 == 0) bursty = ($urandom_range(0, 2) == 0);
         send_vec(pick_comp(), pick_comp(), pick_comp());
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
